// ===== rtl/velocity_yaw_slew_limiter_assert.svh =====
// Assertion macros for the velocity/yaw slew limiter.
// Included by the top level; needs clk and arst_n in scope.
`ifndef VELOCITY_YAW_SLEW_LIMITER_ASSERT_SVH
`define VELOCITY_YAW_SLEW_LIMITER_ASSERT_SVH

// same-cycle implication
`define VYSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VYSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/vysl_pkg.sv =====
// Shared types and constants for the velocity/yaw slew limiter.
// No dependencies.
package vysl_pkg;

	localparam int MUL_W = 18;
	localparam int ACC_W = 36;
	localparam int DEN_W = 19;
	localparam int CNT_W = 5;

	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_SQRT = 2'd1;
	localparam logic [1:0] OP_DIV  = 2'd2;

	localparam logic [2:0] REG_HACCEL = 3'd0;
	localparam logic [2:0] REG_VACCEL = 3'd1;
	localparam logic [2:0] REG_MAXH   = 3'd2;
	localparam logic [2:0] REG_MAXV   = 3'd3;
	localparam logic [2:0] REG_YRATE  = 3'd4;

	localparam logic [CNT_W-1:0] SQRT_STEPS = 5'd17;
	localparam logic [CNT_W-1:0] DIV_STEPS  = 5'd15;

	typedef struct packed {
		logic             start;
		logic [1:0]       op;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
		logic [ACC_W-1:0] num;
		logic [DEN_W-1:0] den;
	} unit_req_t;

endpackage

// ===== rtl/vysl_unit.sv =====
// Shared arithmetic unit: registered 18x18 multiply, bit-serial square root,
// restoring divide with 16 quotient bits. Depends on vysl_pkg.
module vysl_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vysl_pkg::unit_req_t         req,
	output logic                        done,
	output logic [vysl_pkg::ACC_W-1:0]  res
);

	logic                        busy_q;
	logic                        done_q;
	logic [1:0]                  op_q;
	logic [vysl_pkg::CNT_W-1:0]  cnt_q;
	logic [vysl_pkg::ACC_W-1:0]  acc_q;
	logic [vysl_pkg::ACC_W-1:0]  res_q;
	logic [vysl_pkg::DEN_W-1:0]  den_q;

	logic [vysl_pkg::ACC_W-1:0]  bitv;
	logic [vysl_pkg::ACC_W-1:0]  trial;
	logic [vysl_pkg::ACC_W-1:0]  dsh;

	assign bitv  = vysl_pkg::ACC_W'(1) << {cnt_q, 1'b0};
	assign trial = res_q + bitv;
	assign dsh   = vysl_pkg::ACC_W'(den_q) << cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= vysl_pkg::OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				case (req.op)
					vysl_pkg::OP_SQRT: begin
						busy_q <= 1'b1;
						cnt_q  <= vysl_pkg::SQRT_STEPS;
					end
					vysl_pkg::OP_DIV: begin
						busy_q <= 1'b1;
						cnt_q  <= vysl_pkg::DIV_STEPS;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.num;
			den_q <= req.den;
			if (req.op == vysl_pkg::OP_MUL)
				res_q <= req.a * req.b;
			else
				res_q <= '0;
		end else if (busy_q) begin
			if (op_q == vysl_pkg::OP_SQRT) begin
				if (acc_q >= trial) begin
					acc_q <= acc_q - trial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end else begin
				if (acc_q >= dsh) begin
					acc_q <= acc_q - dsh;
					res_q <= res_q | (vysl_pkg::ACC_W'(1) << cnt_q);
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/velocity_yaw_slew_limiter.sv =====
// Each request runs four vector clamps on the shared multiply/sqrt/divide
// unit; each clamp squares x, y and the limit, and if the vector is over it
// takes a sqrt, then scales x and then y by a multiply and a divide. One
// request is processed at a time; the next request is taken while the result
// waits in the output regs. Config is taken only while idle.
// Reset: registers to defaults, command state zero, first request seeds.
module velocity_yaw_slew_limiter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        time_step,
	input  logic signed [15:0] meas_vx,
	input  logic signed [15:0] meas_vy,
	input  logic signed [15:0] meas_vz,
	input  logic signed [15:0] meas_yaw,
	input  logic signed [15:0] goal_vx,
	input  logic signed [15:0] goal_vy,
	input  logic signed [15:0] goal_vz,
	input  logic signed [15:0] goal_yaw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_vx,
	output logic signed [15:0] out_vy,
	output logic signed [15:0] out_vz,
	output logic signed [15:0] out_yaw,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [14:0]        cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HSTEP = 4'd1;
	localparam logic [3:0] S_HADD  = 4'd2;
	localparam logic [3:0] S_VSTEP = 4'd3;
	localparam logic [3:0] S_HMEAS = 4'd4;
	localparam logic [3:0] S_YSTEP = 4'd5;
	localparam logic [3:0] S_DONE  = 4'd6;
	localparam logic [3:0] S_CL_XX = 4'd7;
	localparam logic [3:0] S_CL_YY = 4'd8;
	localparam logic [3:0] S_CL_LL = 4'd9;
	localparam logic [3:0] S_CL_SQ = 4'd10;
	localparam logic [3:0] S_CL_MX = 4'd11;
	localparam logic [3:0] S_CL_DX = 4'd12;
	localparam logic [3:0] S_CL_MY = 4'd13;
	localparam logic [3:0] S_CL_DY = 4'd14;

	logic [3:0]  st_q, ret_q;
	logic        issued_q, seeded_q, out_valid_q;
	logic [14:0] haccel_q, vaccel_q, maxh_q, maxv_q, yrate_q;

	logic [15:0]        dt_q;
	logic signed [15:0] mx_q, my_q, mz_q, gx_q, gy_q, gz_q;
	logic [15:0]        myaw_q, gyaw_q, yaw1_q;
	logic signed [15:0] last_vx_q, last_vy_q, last_vz_q;
	logic [15:0]        last_yaw_q;
	logic signed [17:0] vx_q, vy_q;
	logic [14:0]        lim_q;
	logic [35:0]        t_q;
	logic [17:0]        m_q;
	logic signed [15:0] cz_q;

	vysl_pkg::unit_req_t u_req;
	logic                u_done;
	logic [35:0]         u_res;

	vysl_unit u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (u_req),
		.done  (u_done),
		.res   (u_res)
	);

	function automatic logic signed [15:0] clamp_sym(input logic signed [17:0] v,
			input logic [14:0] lim);
		logic signed [17:0] l;
		l = $signed({3'b000, lim});
		if (v > l)
			return l[15:0];
		else if (v < -l)
			return 16'(-l);
		else
			return v[15:0];
	endfunction

	function automatic logic [16:0] abs16(input logic [15:0] d);
		return d[15] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
	endfunction

	logic        in_acc;
	logic [17:0] ax, ay;
	logic [31:0] rsum;
	logic [14:0] stp;
	logic [17:0] qs;

	assign in_acc    = in_valid && in_ready;
	assign in_ready  = (st_q == S_IDLE);
	assign cfg_ready = (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_vx    = last_vx_q;
	assign out_vy    = last_vy_q;
	assign out_vz    = last_vz_q;
	assign out_yaw   = last_yaw_q;

	assign ax   = vx_q[17] ? 18'(-vx_q) : vx_q;
	assign ay   = vy_q[17] ? 18'(-vy_q) : vy_q;
	assign rsum = u_res[31:0] + 32'd32768;
	assign stp  = rsum[30:16];
	assign qs   = {2'b00, u_res[15:0]};

	// unit request per state
	always_comb begin
		u_req.start = 1'b0;
		u_req.op    = vysl_pkg::OP_MUL;
		u_req.a     = '0;
		u_req.b     = '0;
		u_req.num   = t_q;
		u_req.den   = {m_q, 1'b0};
		case (st_q)
			S_HSTEP: begin
				u_req.start = !issued_q;
				u_req.a     = {3'b000, haccel_q};
				u_req.b     = {2'b00, dt_q};
			end
			S_VSTEP: begin
				u_req.start = !issued_q;
				u_req.a     = {3'b000, vaccel_q};
				u_req.b     = {2'b00, dt_q};
			end
			S_YSTEP: begin
				u_req.start = !issued_q;
				u_req.a     = {3'b000, yrate_q};
				u_req.b     = {2'b00, dt_q};
			end
			S_CL_XX: begin
				u_req.start = !issued_q;
				u_req.a     = ax;
				u_req.b     = ax;
			end
			S_CL_YY: begin
				u_req.start = !issued_q;
				u_req.a     = ay;
				u_req.b     = ay;
			end
			S_CL_LL: begin
				u_req.start = !issued_q;
				u_req.a     = {3'b000, lim_q};
				u_req.b     = {3'b000, lim_q};
			end
			S_CL_SQ: begin
				u_req.start = !issued_q;
				u_req.op    = vysl_pkg::OP_SQRT;
			end
			S_CL_MX: begin
				u_req.start = !issued_q;
				u_req.a     = ax;
				u_req.b     = {3'b000, lim_q};
			end
			S_CL_MY: begin
				u_req.start = !issued_q;
				u_req.a     = ay;
				u_req.b     = {3'b000, lim_q};
			end
			S_CL_DX, S_CL_DY: begin
				u_req.start = !issued_q;
				u_req.op    = vysl_pkg::OP_DIV;
			end
			default: begin
				u_req.start = 1'b0;
			end
		endcase
	end

	// vertical step toward goal
	logic signed [16:0] dz1;
	logic [16:0]        adz1, vst;
	logic signed [17:0] cz_a;
	assign dz1  = 17'(gz_q) - 17'(last_vz_q);
	assign adz1 = dz1[16] ? 17'(-dz1) : dz1;
	assign vst  = (adz1 < {2'b00, stp}) ? adz1 : {2'b00, stp};
	assign cz_a = (gz_q > last_vz_q) ? 18'(last_vz_q) + $signed({1'b0, vst})
		: 18'(last_vz_q) - $signed({1'b0, vst});

	// vertical hold near measurement
	logic signed [16:0] dz2;
	logic [16:0]        adz2, vlim, vst2;
	logic signed [17:0] cz_b;
	assign dz2  = 17'(cz_q) - 17'(mz_q);
	assign adz2 = dz2[16] ? 17'(-dz2) : dz2;
	assign vlim = {1'b0, vaccel_q, 1'b0};
	assign vst2 = (adz2 > vlim) ? vlim : adz2;
	assign cz_b = (cz_q > mz_q) ? 18'(mz_q) + $signed({1'b0, vst2})
		: 18'(mz_q) - $signed({1'b0, vst2});

	// yaw step and hold
	logic [15:0] dy1, dy2, ys16, yaw2;
	logic [16:0] ady1, ady2, ys;
	assign dy1  = gyaw_q - last_yaw_q;
	assign ady1 = abs16(dy1);
	assign ys   = (ady1 < {2'b00, stp}) ? ady1 : {2'b00, stp};
	assign ys16 = ys[15:0];
	assign dy2  = yaw1_q - myaw_q;
	assign ady2 = abs16(dy2);
	assign yaw2 = (ady2 > {2'b00, yrate_q})
		? (dy2[15] ? myaw_q - {1'b0, yrate_q} : myaw_q + {1'b0, yrate_q}) : yaw1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ret_q       <= S_IDLE;
			issued_q    <= 1'b0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
			haccel_q    <= 15'd512;
			vaccel_q    <= 15'd256;
			maxh_q      <= 15'd2560;
			maxv_q      <= 15'd768;
			yrate_q     <= 15'd8192;
			last_vx_q   <= '0;
			last_vy_q   <= '0;
			last_vz_q   <= '0;
			last_yaw_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					vysl_pkg::REG_HACCEL: haccel_q <= cfg_data;
					vysl_pkg::REG_VACCEL: vaccel_q <= cfg_data;
					vysl_pkg::REG_MAXH:   maxh_q   <= cfg_data;
					vysl_pkg::REG_MAXV:   maxv_q   <= cfg_data;
					vysl_pkg::REG_YRATE:  yrate_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && st_q != S_DONE)
				out_valid_q <= 1'b0;
			if (u_req.start)
				issued_q <= 1'b1;
			if (u_done)
				issued_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						st_q <= S_HSTEP;
						if (!seeded_q) begin
							seeded_q   <= 1'b1;
							last_vx_q  <= meas_vx;
							last_vy_q  <= meas_vy;
							last_vz_q  <= meas_vz;
							last_yaw_q <= meas_yaw;
						end
					end
				end
				S_HSTEP: begin
					if (u_done) begin
						vx_q  <= 18'(gx_q) - 18'(last_vx_q);
						vy_q  <= 18'(gy_q) - 18'(last_vy_q);
						lim_q <= stp;
						ret_q <= S_HADD;
						st_q  <= S_CL_XX;
					end
				end
				S_HADD: begin
					vx_q  <= 18'(last_vx_q) + vx_q;
					vy_q  <= 18'(last_vy_q) + vy_q;
					lim_q <= maxh_q;
					ret_q <= S_VSTEP;
					st_q  <= S_CL_XX;
				end
				S_VSTEP: begin
					if (u_done) begin
						cz_q  <= clamp_sym(cz_a, maxv_q);
						vx_q  <= vx_q - 18'(mx_q);
						vy_q  <= vy_q - 18'(my_q);
						lim_q <= haccel_q;
						ret_q <= S_HMEAS;
						st_q  <= S_CL_XX;
					end
				end
				S_HMEAS: begin
					vx_q  <= 18'(mx_q) + vx_q;
					vy_q  <= 18'(my_q) + vy_q;
					lim_q <= maxh_q;
					ret_q <= S_YSTEP;
					st_q  <= S_CL_XX;
				end
				S_YSTEP: begin
					if (u_done) begin
						cz_q   <= clamp_sym(cz_b, maxv_q);
						yaw1_q <= dy1[15] ? last_yaw_q - ys16 : last_yaw_q + ys16;
						st_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						last_vx_q   <= vx_q[15:0];
						last_vy_q   <= vy_q[15:0];
						last_vz_q   <= cz_q;
						last_yaw_q  <= yaw2;
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				S_CL_XX: begin
					if (u_done) begin
						t_q  <= u_res;
						st_q <= S_CL_YY;
					end
				end
				S_CL_YY: begin
					if (u_done) begin
						t_q  <= t_q + u_res;
						st_q <= S_CL_LL;
					end
				end
				S_CL_LL: begin
					if (u_done)
						st_q <= (t_q <= u_res) ? ret_q : S_CL_SQ;
				end
				S_CL_SQ: begin
					if (u_done) begin
						m_q  <= u_res[17:0];
						st_q <= S_CL_MX;
					end
				end
				S_CL_MX, S_CL_MY: begin
					if (u_done) begin
						t_q  <= {u_res[34:0], 1'b0} + 36'(m_q);
						st_q <= (st_q == S_CL_MX) ? S_CL_DX : S_CL_DY;
					end
				end
				S_CL_DX: begin
					if (u_done) begin
						vx_q <= vx_q[17] ? -$signed(qs) : $signed(qs);
						st_q <= S_CL_MY;
					end
				end
				S_CL_DY: begin
					if (u_done) begin
						vy_q <= vy_q[17] ? -$signed(qs) : $signed(qs);
						st_q <= ret_q;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dt_q   <= time_step;
			mx_q   <= meas_vx;
			my_q   <= meas_vy;
			mz_q   <= meas_vz;
			myaw_q <= meas_yaw;
			gx_q   <= goal_vx;
			gy_q   <= goal_vy;
			gz_q   <= goal_vz;
			gyaw_q <= goal_yaw;
		end
	end

`include "velocity_yaw_slew_limiter_assert.svh"

	`VYSL_ASSERT_NEXT(a_seed_after_accept, in_acc, seeded_q, "not seeded after request")
	`VYSL_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(st_q) == S_DONE, "result not from done")
	`VYSL_ASSERT_NOW(a_unit_done_issued, u_done, issued_q, "unit done without request")

endmodule
